// ===== sv/icf_pkg.sv =====
// Package for the inverter link block: item kinds, frame identifiers,
// offsets and the security byte table. No dependencies.
`timescale 1ns / 1ps

package icf_pkg;

   // Kind of a queued item, set by the front end.
   typedef logic [2:0] op_kind_type;
   localparam op_kind_type OP_TICK     = 3'd0;
   localparam op_kind_type OP_FEEDBACK = 3'd1;
   localparam op_kind_type OP_TEMPS    = 3'd2;
   localparam op_kind_type OP_WATCHDOG = 3'd3;
   localparam op_kind_type OP_ACTIVE   = 3'd4;
   localparam op_kind_type OP_OTHER    = 3'd5;

   localparam logic [10:0] ID_COMMAND  = 11'h204;
   localparam logic [10:0] ID_WD_RESET = 11'h207;
   localparam logic [10:0] ID_FEEDBACK = 11'h209;
   localparam logic [10:0] ID_ACT_LOW  = 11'h20A;
   localparam logic [10:0] ID_ACT_HIGH = 11'h20D;
   localparam logic [10:0] ID_TEMPS    = 11'h20E;
   localparam logic [10:0] ID_WATCHDOG = 11'h20F;

   localparam logic signed [16:0] TORQUE_OFFSET = 17'sd32128;
   localparam logic signed [12:0] TEMP_OFFSET   = 13'sd40;
   localparam logic signed [12:0] TEMP_SCALE    = 13'sd10;

   localparam logic [63:0] WD_DATA = 64'h0000_0000_005A_A5A5;

   localparam logic [7:0] SEC_INIT = 8'h7F;
   localparam logic [7:0] SEC_TABLE [16] = '{
      8'hAA, 8'h7F, 8'hFE, 8'h29, 8'h52, 8'hA4, 8'h9D, 8'hEF,
      8'h0B, 8'h16, 8'h2C, 8'h58, 8'hB0, 8'h60, 8'hC0, 8'h01
   };

   localparam int unsigned SPEED_LIMIT_W = 16;
   localparam logic [SPEED_LIMIT_W-1:0] SPEED_LIMIT_RESET = 16'd6000;

   localparam logic [0:0] REG_SPEED_LIMIT = 1'd0;
   localparam logic [0:0] REG_INVERT_DIR  = 1'd1;

   // One classified item as it travels from the front end to the back end.
   typedef struct packed {
      op_kind_type        kind;
      logic               ready_flag;
      logic               power_on;
      logic               gear_drive;
      logic signed [15:0] torque_request;
      logic signed [16:0] torque;
      logic signed [16:0] voltage;
      logic signed [16:0] current;
      logic        [14:0] speed;
      logic signed [12:0] inv_temp;
      logic signed [12:0] mot_temp;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== sv/icf_if.sv =====
// Channel interfaces for the inverter link block: request and response.
// No dependencies.
`timescale 1ns / 1ps

interface icf_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic        [10:0] frame_id;
   logic        [63:0] frame_data;
   logic               ready_flag;
   logic               power_on;
   logic               gear_drive;
   logic signed [15:0] torque_request;

   modport source (output valid, command, frame_id, frame_data, ready_flag, power_on,
                   gear_drive, torque_request, input ready);
   modport sink (input valid, command, frame_id, frame_data, ready_flag, power_on,
                 gear_drive, torque_request, output ready);
endinterface

interface icf_rsp_if;
   logic               valid;
   logic               ready;
   logic               send_valid;
   logic        [10:0] send_id;
   logic        [63:0] send_data;
   logic signed [16:0] torque_actual;
   logic signed [16:0] dc_voltage;
   logic signed [16:0] dc_current;
   logic        [14:0] speed_actual;
   logic signed [12:0] controller_temp;
   logic signed [12:0] motor_temp;
   logic               running;
   logic               activity;

   modport source (output valid, send_valid, send_id, send_data, torque_actual, dc_voltage,
                   dc_current, speed_actual, controller_temp, motor_temp, running,
                   activity, input ready);
   modport sink (input valid, send_valid, send_id, send_data, torque_actual, dc_voltage,
                 dc_current, speed_actual, controller_temp, motor_temp, running,
                 activity, output ready);
endinterface

// ===== sv/inverter_can_command_and_feedback.sv =====
// Top level of the inverter link block: configuration registers, front end,
// item queue and back end. Depends on icf_pkg, icf_if, icf_front, icf_queue, icf_back.
//
// Each request item is either a transmit tick (command = 0) or a received frame
// (command = 1). Every request item gives exactly one response item that carries
// the frame to transmit, if any, and the stored feedback after the item.
// The request channel is accepted when valid and ready are high at a clock edge;
// ready is low only while the item queue is full.
// An accepted item is written into the queue and, once at its head, is executed by the
// back end into the response register, which drives the response channel.
// Throughput: one item per cycle while the receiver takes responses; the back end
// executes one item per cycle from the queue into the response register.
// When the receiver stalls, the response register holds and the queue takes up to
// QUEUE_DEPTH further items before request ready drops.
// Reset (synchronous, active high) empties the queue, clears the sequence counter,
// running flag and stored feedback, and loads the speed limit with 6000 rpm and the
// direction override with zero. The user writes csr register 0 (speed limit) or 1
// (direction override) only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps

module inverter_can_command_and_feedback #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   icf_req_if.sink                             req_bus,
   icf_rsp_if.source                           rsp_bus,
   input  logic                                csr_we,
   input  logic [0:0]                          csr_index,
   input  logic [icf_pkg::SPEED_LIMIT_W-1:0]   csr_wdata
);
   import icf_pkg::*;

   logic [SPEED_LIMIT_W-1:0] speed_limit_ff, speed_limit_in;
   logic                     invert_dir_ff, invert_dir_in;

   op_type       front_op;
   op_type       head_op;
   q_status_type q_status;
   logic         push;
   logic         pop;

   always_comb begin
      speed_limit_in = speed_limit_ff;
      invert_dir_in  = invert_dir_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_SPEED_LIMIT: speed_limit_in = csr_wdata;
            REG_INVERT_DIR:  invert_dir_in  = csr_wdata[0];
            default:         speed_limit_in = speed_limit_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_limit_ff <= SPEED_LIMIT_RESET;
         invert_dir_ff  <= 1'b0;
      end else begin
         speed_limit_ff <= speed_limit_in;
         invert_dir_ff  <= invert_dir_in;
      end
   end

   icf_front u_front (
      .req_bus  (req_bus),
      .q_status (q_status),
      .push     (push),
      .op       (front_op)
   );

   icf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (front_op),
      .pop     (pop),
      .head_op (head_op),
      .status  (q_status)
   );

   icf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .speed_limit      (speed_limit_ff),
      .invert_direction (invert_dir_ff),
      .head_op          (head_op),
      .q_status         (q_status),
      .pop              (pop),
      .rsp_bus          (rsp_bus)
   );

endmodule

// ===== sv/icf_front.sv =====
// Front end: accepts request items, classifies them by identifier and
// decodes the feedback values. Depends on icf_pkg and icf_req_if.
`timescale 1ns / 1ps

module icf_front (
   icf_req_if.sink          req_bus,
   input  icf_pkg::q_status_type q_status,
   output logic             push,
   output icf_pkg::op_type  op
);
   import icf_pkg::*;

   function automatic logic signed [16:0] offset_pair(input logic [15:0] pair);
      return $signed({1'b0, pair}) - TORQUE_OFFSET;
   endfunction

   function automatic logic signed [12:0] temp_of(input logic [7:0] raw);
      logic signed [12:0] diff;
      diff = $signed({5'b0, raw}) - TEMP_OFFSET;
      return diff * TEMP_SCALE;
   endfunction

   logic signed [16:0] speed_raw;
   logic signed [16:0] speed_mag;
   logic        [7:0]  rotor_byte;
   logic        [7:0]  stator_byte;

   assign req_bus.ready = !q_status.full;
   assign push          = req_bus.valid && !q_status.full;

   always_comb begin
      op.ready_flag     = req_bus.ready_flag;
      op.power_on       = req_bus.power_on;
      op.gear_drive     = req_bus.gear_drive;
      op.torque_request = req_bus.torque_request;
      op.torque         = offset_pair(req_bus.frame_data[15:0]);
      op.voltage        = offset_pair(req_bus.frame_data[31:16]);
      op.current        = offset_pair(req_bus.frame_data[47:32]);

      // Halving toward zero and then taking the magnitude is the magnitude halved.
      speed_raw = offset_pair(req_bus.frame_data[63:48]);
      speed_mag = speed_raw[16] ? -speed_raw : speed_raw;
      op.speed  = speed_mag[15:1];

      rotor_byte  = req_bus.frame_data[31:24];
      stator_byte = req_bus.frame_data[39:32];
      op.inv_temp = temp_of(req_bus.frame_data[23:16]);
      op.mot_temp = temp_of((rotor_byte > stator_byte) ? rotor_byte : stator_byte);

      priority if (!req_bus.command) begin
         op.kind = OP_TICK;
      end else if (req_bus.frame_id == ID_FEEDBACK) begin
         op.kind = OP_FEEDBACK;
      end else if (req_bus.frame_id == ID_TEMPS) begin
         op.kind = OP_TEMPS;
      end else if (req_bus.frame_id == ID_WATCHDOG) begin
         op.kind = OP_WATCHDOG;
      end else if (req_bus.frame_id >= ID_ACT_LOW && req_bus.frame_id <= ID_ACT_HIGH) begin
         op.kind = OP_ACTIVE;
      end else begin
         op.kind = OP_OTHER;
      end
   end

endmodule

// ===== sv/icf_queue.sv =====
// Short queue of classified items between the front and back ends.
// Depends on icf_pkg.
`timescale 1ns / 1ps

module icf_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  icf_pkg::op_type       push_op,
   input  logic                  pop,
   output icf_pkg::op_type       head_op,
   output icf_pkg::q_status_type status
);
   import icf_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   op_type             entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_op      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count exceeds depth");

endmodule

// ===== sv/icf_back.sv =====
// Back end: holds the link state, executes queued items, builds the command
// and watchdog frames and registers the response. Depends on icf_pkg, icf_rsp_if.
`timescale 1ns / 1ps

module icf_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [icf_pkg::SPEED_LIMIT_W-1:0]      speed_limit,
   input  logic                                   invert_direction,
   input  icf_pkg::op_type                        head_op,
   input  icf_pkg::q_status_type                  q_status,
   output logic                                   pop,
   icf_rsp_if.source                              rsp_bus
);
   import icf_pkg::*;

   logic [2:0]         seq_ff, seq_in;
   logic               running_ff, running_in;
   logic signed [16:0] torque_ff, torque_in;
   logic signed [16:0] voltage_ff, voltage_in;
   logic signed [16:0] current_ff, current_in;
   logic        [14:0] speed_ff, speed_in;
   logic signed [12:0] inv_temp_ff, inv_temp_in;
   logic signed [12:0] mot_temp_ff, mot_temp_in;
   logic               out_valid_ff, out_valid_in;
   logic               send_valid_ff, send_valid_in;
   logic        [10:0] send_id_ff, send_id_in;
   logic        [63:0] send_data_ff, send_data_in;
   logic               activity_ff, activity_in;

   logic        [2:0]  seq_next;
   logic        [7:0]  cmd_byte;
   logic signed [16:0] req_wide;
   logic signed [16:0] req_round;
   logic signed [16:0] req_half;
   logic signed [16:0] word_wide;
   logic        [15:0] word;
   logic        [15:0] sec_t1;
   logic        [15:0] sec_t2;
   logic        [7:0]  sec_byte;
   logic               slow;

   assign pop = !q_status.empty && (!out_valid_ff || rsp_bus.ready);

   // Torque command frame, built from the head item whether or not it is a tick.
   always_comb begin
      seq_next = seq_ff + 3'd1;
      cmd_byte = {((head_op.ready_flag || running_ff) && head_op.power_on) ? 2'b10 : 2'b01,
                  (head_op.gear_drive && !invert_direction) ? 2'b10 : 2'b01,
                  1'b0, seq_next};
      slow      = ({1'b0, speed_ff} < speed_limit);
      req_wide  = {head_op.torque_request[15], head_op.torque_request};
      req_round = req_wide + $signed({16'b0, head_op.torque_request[15]});
      req_half  = req_round >>> 1;
      word_wide = TORQUE_OFFSET + (slow ? req_wide : req_half);
      word      = word_wide[15:0];
      sec_t1    = word + {15'b0, (cmd_byte[7] && cmd_byte[5]) || (cmd_byte[6] && cmd_byte[5])};
      sec_t2    = (sec_t1[1:0] == 2'b11) ? sec_t1 + 16'd4 : sec_t1;
      sec_byte  = SEC_INIT;
      for (int i = 0; i < 16; i++) begin
         if (sec_t2[i]) begin
            sec_byte = sec_byte ^ SEC_TABLE[i];
         end
      end
   end

   always_comb begin
      seq_in        = seq_ff;
      running_in    = running_ff;
      torque_in     = torque_ff;
      voltage_in    = voltage_ff;
      current_in    = current_ff;
      speed_in      = speed_ff;
      inv_temp_in   = inv_temp_ff;
      mot_temp_in   = mot_temp_ff;
      send_valid_in = send_valid_ff;
      send_id_in    = send_id_ff;
      send_data_in  = send_data_ff;
      activity_in   = activity_ff;
      out_valid_in  = pop ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);
      if (pop) begin
         send_valid_in = 1'b0;
         send_id_in    = '0;
         send_data_in  = '0;
         activity_in   = 1'b0;
         running_in    = 1'b1;
         unique case (head_op.kind)
            OP_TICK: begin
               seq_in        = seq_next;
               running_in    = running_ff;
               send_valid_in = 1'b1;
               send_id_in    = ID_COMMAND;
               send_data_in  = {24'b0, sec_byte, word[15:8], word[7:0], cmd_byte, 8'b0};
            end
            OP_FEEDBACK: begin
               torque_in   = head_op.torque;
               voltage_in  = head_op.voltage;
               current_in  = head_op.current;
               speed_in    = head_op.speed;
               activity_in = 1'b1;
            end
            OP_TEMPS: begin
               inv_temp_in = head_op.inv_temp;
               mot_temp_in = head_op.mot_temp;
               activity_in = 1'b1;
            end
            OP_WATCHDOG: begin
               running_in    = 1'b0;
               send_valid_in = 1'b1;
               send_id_in    = ID_WD_RESET;
               send_data_in  = WD_DATA;
               activity_in   = 1'b1;
            end
            OP_ACTIVE: begin
               activity_in = 1'b1;
            end
            default: begin
               activity_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= '0;
         running_ff   <= 1'b0;
         torque_ff    <= '0;
         voltage_ff   <= '0;
         current_ff   <= '0;
         speed_ff     <= '0;
         inv_temp_ff  <= '0;
         mot_temp_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         running_ff   <= running_in;
         torque_ff    <= torque_in;
         voltage_ff   <= voltage_in;
         current_ff   <= current_in;
         speed_ff     <= speed_in;
         inv_temp_ff  <= inv_temp_in;
         mot_temp_ff  <= mot_temp_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      send_valid_ff <= send_valid_in;
      send_id_ff    <= send_id_in;
      send_data_ff  <= send_data_in;
      activity_ff   <= activity_in;
   end

   // Stored values change only on a pop, so they double as response fields.
   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.send_valid      = send_valid_ff;
   assign rsp_bus.send_id         = send_id_ff;
   assign rsp_bus.send_data       = send_data_ff;
   assign rsp_bus.torque_actual   = torque_ff;
   assign rsp_bus.dc_voltage      = voltage_ff;
   assign rsp_bus.dc_current      = current_ff;
   assign rsp_bus.speed_actual    = speed_ff;
   assign rsp_bus.controller_temp = inv_temp_ff;
   assign rsp_bus.motor_temp      = mot_temp_ff;
   assign rsp_bus.running         = running_ff;
   assign rsp_bus.activity        = activity_ff;

   a_watchdog_frame: assert property (@(posedge clock) disable iff (reset)
      pop && head_op.kind == OP_WATCHDOG |=> !running_ff && send_id_ff == ID_WD_RESET)
      else $error("watchdog item did not clear running or send its frame");

   a_seq_advance: assert property (@(posedge clock) disable iff (reset)
      pop && head_op.kind == OP_TICK |=> seq_ff == $past(seq_ff) + 3'd1)
      else $error("sequence did not advance on a tick");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_bus.ready |-> !pop)
      else $error("item popped while the response is stalled");

endmodule
